### src/sclp_pkg.sv
// Shared types and constants for the serial command line parser.
// It has no dependencies. The parser core, the top level and the port checker import it.
`default_nettype none

package sclp_pkg;

	// A line holds at most LINE_CAPACITY-1 characters.
	localparam int LINE_CAPACITY = 64;
	localparam int CNT_W         = $clog2(LINE_CAPACITY);

	// Line terminators.
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	// Message kinds.
	localparam logic KIND_MOTION = 1'b0;
	localparam logic KIND_LETTER = 1'b1;

	// One parsed message, as it leaves the parser core.
	typedef struct packed {
		logic              valid;
		logic              msg_kind;
		logic signed [31:0] left_value;
		logic signed [31:0] right_value;
		logic [7:0]        flag_bits;
		logic [7:0]        letter;
	} result_t;

endpackage

`default_nettype wire

### src/sclp_core.sv
// Parser core: line state, decimal accumulator, held fields and message decode.
// It depends on sclp_pkg. It takes one byte per step and returns the message at a line end.
`default_nettype none

module sclp_core
	import sclp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	output result_t         res
);

	localparam logic [3:0] PH_START   = 4'd0;
	localparam logic [3:0] PH_PRE_CMD = 4'd1;
	localparam logic [3:0] PH_PRE_ASL = 4'd2;
	localparam logic [3:0] PH_ASL_LET = 4'd3;
	localparam logic [3:0] PH_ASL_OK  = 4'd4;
	localparam logic [3:0] PH_SKIP0   = 4'd5;
	localparam logic [3:0] PH_NUM0    = 4'd6;
	localparam logic [3:0] PH_SKIP1   = 4'd7;
	localparam logic [3:0] PH_NUM1    = 4'd8;
	localparam logic [3:0] PH_SKIP2   = 4'd9;
	localparam logic [3:0] PH_NUM2    = 4'd10;
	localparam logic [3:0] PH_CMD_OK  = 4'd11;
	localparam logic [3:0] PH_FAIL    = 4'd12;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_C     = 8'h43;
	localparam logic [7:0] CHAR_D     = 8'h44;
	localparam logic [7:0] CHAR_L     = 8'h4C;
	localparam logic [7:0] CHAR_M     = 8'h4D;
	localparam logic [7:0] CHAR_S     = 8'h53;

	localparam logic [35:0] LIMIT_POS = 36'h07FFFFFFF;
	localparam logic [35:0] LIMIT_NEG = 36'h080000000;

	logic [CNT_W-1:0] count_q, count_d;
	logic [3:0]       phase_q, phase_d;
	logic [31:0]      accum_q, accum_d;
	logic             neg_q, neg_d;
	logic             seen_q, seen_d;
	logic             ended_q, ended_d;
	logic [31:0]      left_q, left_d;
	logic [31:0]      right_q, right_d;
	logic [7:0]       flags_q, flags_d;
	logic [7:0]       letter_q, letter_d;

	logic             is_term;
	logic             is_blank;
	logic             is_digit;
	logic             is_sign;
	logic [3:0]       digit;
	logic [35:0]      grown;
	logic [35:0]      limit;
	logic [31:0]      accum_next;
	logic [31:0]      num_value;
	logic [7:0]       cmd_char;
	logic [7:0]       asl_char;

	assign is_term  = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
	assign is_blank = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
		(rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);
	assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	assign is_sign  = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
	assign digit    = rx_byte[3:0];

	// Accumulate one digit: accum * 10 + digit, saturated at the signed limit.
	assign grown      = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + {32'b0, digit};
	assign limit      = neg_q ? LIMIT_NEG : LIMIT_POS;
	assign accum_next = (grown > limit) ? limit[31:0] : grown[31:0];
	assign num_value  = neg_q ? (32'd0 - accum_q) : accum_q;

	// Expected prefix characters at the current position.
	always_comb begin
		unique case (count_q)
			CNT_W'(1): begin
				cmd_char = CHAR_M;
				asl_char = CHAR_S;
			end
			CNT_W'(2): begin
				cmd_char = CHAR_D;
				asl_char = CHAR_L;
			end
			CNT_W'(3): begin
				cmd_char = CHAR_NUL;
				asl_char = CHAR_SPACE;
			end
			default: begin
				cmd_char = CHAR_NUL;
				asl_char = CHAR_NUL;
			end
		endcase
	end

	// Next state and message for the byte at the input, as if it were consumed now.
	// The registers take the next state only on a step.
	always_comb begin
		count_d  = count_q;
		phase_d  = phase_q;
		accum_d  = accum_q;
		neg_d    = neg_q;
		seen_d   = seen_q;
		ended_d  = ended_q;
		left_d   = left_q;
		right_d  = right_q;
		flags_d  = flags_q;
		letter_d = letter_q;

		res             = '0;
		res.msg_kind    = KIND_MOTION;

		if (is_term) begin
			if (count_q != '0) begin
				if ((phase_q == PH_NUM2 && seen_q) || phase_q == PH_CMD_OK) begin
					res.valid       = 1'b1;
					res.msg_kind    = KIND_MOTION;
					res.left_value  = left_q;
					res.right_value = right_q;
					res.flag_bits   = (phase_q == PH_NUM2) ? num_value[7:0] : flags_q;
					if (phase_q == PH_NUM2)
						flags_d = num_value[7:0];
				end else if (phase_q == PH_ASL_OK) begin
					res.valid    = 1'b1;
					res.msg_kind = KIND_LETTER;
					res.letter   = letter_q;
				end
				count_d = '0;
				phase_d = PH_START;
				accum_d = '0;
				neg_d   = 1'b0;
				seen_d  = 1'b0;
				ended_d = 1'b0;
			end
		end else if (count_q >= CNT_W'(LINE_CAPACITY - 1)) begin
			// Overlong line: drop this byte and start a fresh line.
			count_d = '0;
			phase_d = PH_START;
			accum_d = '0;
			neg_d   = 1'b0;
			seen_d  = 1'b0;
			ended_d = 1'b0;
		end else begin
			count_d = count_q + CNT_W'(1);
			if (rx_byte == CHAR_NUL) begin
				ended_d = 1'b1;
			end else if (!ended_q) begin
				unique case (phase_q)
					PH_START: begin
						if (rx_byte == CHAR_C)
							phase_d = PH_PRE_CMD;
						else if (rx_byte == CHAR_A)
							phase_d = PH_PRE_ASL;
						else
							phase_d = PH_FAIL;
					end
					PH_PRE_CMD: begin
						if (count_q < CNT_W'(3) && rx_byte == cmd_char)
							phase_d = (count_q == CNT_W'(2)) ? PH_SKIP0 : PH_PRE_CMD;
						else
							phase_d = PH_FAIL;
					end
					PH_PRE_ASL: begin
						if (count_q < CNT_W'(4) && rx_byte == asl_char)
							phase_d = (count_q == CNT_W'(3)) ? PH_ASL_LET : PH_PRE_ASL;
						else
							phase_d = PH_FAIL;
					end
					PH_ASL_LET: begin
						letter_d = rx_byte;
						phase_d  = PH_ASL_OK;
					end
					PH_SKIP0, PH_SKIP1, PH_SKIP2: begin
						if (!is_blank) begin
							// A number starts with a sign or a digit.
							neg_d   = (rx_byte == CHAR_MINUS);
							seen_d  = is_digit;
							accum_d = is_digit ? {28'b0, digit} : 32'd0;
							phase_d = (is_sign || is_digit) ? (phase_q + 4'd1) : PH_FAIL;
						end
					end
					PH_NUM0, PH_NUM1, PH_NUM2: begin
						if (is_digit) begin
							accum_d = accum_next;
							seen_d  = 1'b1;
						end else if (!seen_q) begin
							phase_d = PH_FAIL;
						end else if (phase_q == PH_NUM2) begin
							flags_d = num_value[7:0];
							phase_d = PH_CMD_OK;
						end else begin
							if (phase_q == PH_NUM0)
								left_d = num_value;
							else
								right_d = num_value;
							if (is_blank) begin
								phase_d = phase_q + 4'd1;
							end else begin
								// A signed number may follow directly.
								neg_d   = (rx_byte == CHAR_MINUS);
								seen_d  = 1'b0;
								accum_d = '0;
								phase_d = is_sign ? (phase_q + 4'd2) : PH_FAIL;
							end
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			phase_q  <= PH_START;
			accum_q  <= '0;
			neg_q    <= 1'b0;
			seen_q   <= 1'b0;
			ended_q  <= 1'b0;
			left_q   <= '0;
			right_q  <= '0;
			flags_q  <= '0;
			letter_q <= '0;
		end else if (step) begin
			count_q  <= count_d;
			phase_q  <= phase_d;
			accum_q  <= accum_d;
			neg_q    <= neg_d;
			seen_q   <= seen_d;
			ended_q  <= ended_d;
			left_q   <= left_d;
			right_q  <= right_d;
			flags_q  <= flags_d;
			letter_q <= letter_d;
		end
	end

endmodule

`default_nettype wire

### src/serial_command_line_parser_unit.sv
// Top level of the serial command line parser: input register, parser core, output register.
// It depends on sclp_pkg and sclp_core.
`default_nettype none

// Channel | Direction | Handshake               | Word
// --------+-----------+-------------------------+----------------------------------------------
// in      | input     | in_valid / in_stall     | rx_byte
// out     | output    | out_valid / out_stall   | msg_kind, left_value, right_value,
//         |           |                         | flag_bits, letter
//
// A byte is registered on acceptance and parsed once the core can step; a message
// is loaded into the output register when the core steps on the CR or LF word that ends its line.
// One word is taken every cycle unless in_stall holds it; the core's parse step sets that rate.
// A message waiting at a stalled output holds back only a byte that would
// produce another message; all other bytes keep flowing.
// Reset is asynchronous and active low, and it empties both registers and the line state.

module serial_command_line_parser_unit
	import sclp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    msg_kind,
	output logic signed [31:0]      left_value,
	output logic signed [31:0]      right_value,
	output logic [7:0]              flag_bits,
	output logic [7:0]              letter
);

	// Input register: holds the byte that the core is to parse.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Output register.
	logic        out_valid_q;
	logic        kind_q;
	logic [31:0] left_q;
	logic [31:0] right_q;
	logic [7:0]  flags_q;
	logic [7:0]  letter_q;

	logic    advance;
	logic    in_take;
	logic    out_take;
	result_t core_res;

	// The core steps on the registered byte unless it would produce a message while the
	// output register still holds one that the consumer is stalling.
	assign advance  = valid_s1 && !(core_res.valid && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	sclp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			byte_s1 <= rx_byte;
	end

	// Message register: loaded when the core returns a message at a line end, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && core_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_res.valid) begin
			kind_q   <= core_res.msg_kind;
			left_q   <= core_res.left_value;
			right_q  <= core_res.right_value;
			flags_q  <= core_res.flag_bits;
			letter_q <= core_res.letter;
		end
	end

	assign out_valid   = out_valid_q;
	assign msg_kind    = kind_q;
	assign left_value  = left_q;
	assign right_value = right_q;
	assign flag_bits   = flags_q;
	assign letter      = letter_q;

endmodule

`default_nettype wire

### src/sclp_checker.sv
// Port checker for the serial command line parser, bound to the top level.
// It depends on sclp_pkg and watches only the ports of serial_command_line_parser_unit.
`default_nettype none

module sclp_checker
	import sclp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  rx_byte,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        msg_kind,
	input wire logic [31:0] left_value,
	input wire logic [31:0] right_value,
	input wire logic [7:0]  flag_bits,
	input wire logic [7:0]  letter
);

	// A stalled message holds its word.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(msg_kind) && $stable(left_value) &&
			$stable(right_value) && $stable(flag_bits) && $stable(letter))
		else $error("stalled message changed");

	// A letter message carries zero numbers and a nonzero letter.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_kind == KIND_LETTER |->
			left_value == 32'd0 && right_value == 32'd0 && flag_bits == 8'd0 && letter != 8'd0)
		else $error("letter message has bad fields");

	// A motion message carries no letter.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_kind == KIND_MOTION |-> letter == 8'd0)
		else $error("motion message has a letter");

	// A new message follows a line terminator that was accepted at the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall &&
			(rx_byte == CHAR_LF || rx_byte == CHAR_CR), 2))
		else $error("message without a line terminator");

endmodule

bind serial_command_line_parser_unit sclp_checker u_sclp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.rx_byte     (rx_byte),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.msg_kind    (msg_kind),
	.left_value  (left_value),
	.right_value (right_value),
	.flag_bits   (flag_bits),
	.letter      (letter)
);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// Testbench for serial_command_line_parser_unit: random text lines in, parsed messages checked out.
// It depends on sclp_pkg and serial_command_line_parser_unit; it reads nothing else.

module tb;
	import sclp_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_WORDS = 1650;
	localparam int IDLE_PERCENT = 17;
	// Generous: a clean run ends well before this limit.
	localparam int CYCLE_LIMIT  = 200000;
	// A message passes the input and output registers after its terminator; this extra wait comes at the end.
	localparam int DRAIN_CYCLES = 20;
	// Stretches with no idling, one on each side.
	localparam int SEND_CALM_FROM  = 500;
	localparam int SEND_CALM_TO    = 900;
	localparam int STALL_CALM_FROM = 1000;
	localparam int STALL_CALM_TO   = 1500;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Where the parser stands within the current line.
	typedef enum logic [3:0] {
		LINE_START, CMD_WORD, ASL_WORD, LETTER_POS, ASL_MATCH,
		GAP_LEFT, NUM_LEFT, GAP_RIGHT, NUM_RIGHT, GAP_FLAGS, NUM_FLAGS,
		CMD_MATCH, NO_MATCH
	} line_phase_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] left;
		logic signed [31:0] right;
		logic [7:0]         flags;
		logic [7:0]         letter;
	} line_msg_t;

	// Line parser mirror plus the queue of messages it has promised, oldest first.
	class line_scoreboard;
		line_msg_t   expected_msgs[$];
		int          errors;
		string       cmd_prefix = "CMD";
		string       asl_prefix = "ASL ";
		int unsigned char_count;
		line_phase_t phase;
		logic [31:0] magnitude;
		bit          negative;
		bit          digit_seen;
		bit          text_ended;
		logic [31:0] last_left;
		logic [31:0] last_right;
		logic [7:0]  last_flags;
		logic [7:0]  last_letter;

		function new();
			errors = 0;
			last_left = 0;
			last_right = 0;
			last_flags = 0;
			last_letter = 0;
			clear_line();
		endfunction

		function void clear_line();
			char_count = 0;
			phase = LINE_START;
			magnitude = 0;
			negative = 0;
			digit_seen = 0;
			text_ended = 0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		// The magnitude saturates one higher for a negative number.
		function void add_digit(logic [7:0] c);
			logic [63:0] sum;
			logic [63:0] ceiling;
			ceiling = negative ? 64'd2147483648 : 64'd2147483647;
			sum = 64'(magnitude) * 64'd10 + 64'(c - CH_ZERO);
			if (sum > ceiling)
				sum = ceiling;
			magnitude = sum[31:0];
			digit_seen = 1;
		endfunction

		function logic [31:0] number_value();
			return negative ? -magnitude : magnitude;
		endfunction

		function void start_number(line_phase_t target, logic [7:0] c);
			magnitude = 0;
			digit_seen = 0;
			negative = (c == CH_MINUS);
			if (c == CH_PLUS || c == CH_MINUS) begin
				phase = target;
			end else if (is_digit(c)) begin
				phase = target;
				add_digit(c);
			end else begin
				phase = NO_MATCH;
			end
		endfunction

		function void number_char(logic [7:0] c);
			logic [31:0] value;
			value = number_value();
			if (is_digit(c)) begin
				add_digit(c);
			end else if (!digit_seen) begin
				phase = NO_MATCH;
			end else if (phase == NUM_FLAGS) begin
				last_flags = value[7:0];
				phase = CMD_MATCH;
			end else if (phase == NUM_LEFT) begin
				last_left = value;
				if (is_blank(c))
					phase = GAP_RIGHT;
				else
					start_number(NUM_RIGHT, c);
			end else begin
				last_right = value;
				if (is_blank(c))
					phase = GAP_FLAGS;
				else
					start_number(NUM_FLAGS, c);
			end
		endfunction

		function void parse_char(logic [7:0] c);
			case (phase)
				LINE_START: begin
					if (c == "C")
						phase = CMD_WORD;
					else if (c == "A")
						phase = ASL_WORD;
					else
						phase = NO_MATCH;
				end
				CMD_WORD: begin
					if (char_count < 3 && c == cmd_prefix[char_count])
						phase = (char_count == 2) ? GAP_LEFT : CMD_WORD;
					else
						phase = NO_MATCH;
				end
				ASL_WORD: begin
					if (char_count < 4 && c == asl_prefix[char_count])
						phase = (char_count == 3) ? LETTER_POS : ASL_WORD;
					else
						phase = NO_MATCH;
				end
				LETTER_POS: begin
					last_letter = c;
					phase = ASL_MATCH;
				end
				GAP_LEFT:  if (!is_blank(c)) start_number(NUM_LEFT, c);
				GAP_RIGHT: if (!is_blank(c)) start_number(NUM_RIGHT, c);
				GAP_FLAGS: if (!is_blank(c)) start_number(NUM_FLAGS, c);
				NUM_LEFT, NUM_RIGHT, NUM_FLAGS: number_char(c);
				default: ;
			endcase
		endfunction

		// Called for every accepted input word.
		function void note_word(logic [7:0] c);
			line_msg_t msg;
			logic [31:0] value;
			if (c == CHAR_LF || c == CHAR_CR) begin
				if (char_count == 0)
					return;
				if (phase == NUM_FLAGS && digit_seen) begin
					value = number_value();
					last_flags = value[7:0];
					phase = CMD_MATCH;
				end
				if (phase == CMD_MATCH) begin
					msg.kind = KIND_MOTION;
					msg.left = last_left;
					msg.right = last_right;
					msg.flags = last_flags;
					msg.letter = 8'h00;
					expected_msgs.push_back(msg);
				end else if (phase == ASL_MATCH) begin
					msg.kind = KIND_LETTER;
					msg.left = 0;
					msg.right = 0;
					msg.flags = 8'h00;
					msg.letter = last_letter;
					expected_msgs.push_back(msg);
				end
				clear_line();
				return;
			end
			// A full line drops this character and starts over empty.
			if (char_count >= LINE_CAPACITY - 1) begin
				clear_line();
				return;
			end
			if (c == CH_NUL)
				text_ended = 1;
			else if (!text_ended)
				parse_char(c);
			char_count++;
		endfunction

		task report(string what);
			if (errors < 100)
				$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		// Called for every accepted output word.
		task check_word(logic kind, logic signed [31:0] left, logic signed [31:0] right,
				logic [7:0] flags, logic [7:0] letter);
			line_msg_t want;
			if (expected_msgs.size() == 0) begin
				report($sformatf("message with none expected: kind %0d left %0d right %0d",
					kind, left, right));
				return;
			end
			want = expected_msgs.pop_front();
			if (kind !== want.kind)
				report($sformatf("msg_kind %0d, expected %0d", kind, want.kind));
			if (left !== want.left)
				report($sformatf("left_value %0d, expected %0d", left, want.left));
			if (right !== want.right)
				report($sformatf("right_value %0d, expected %0d", right, want.right));
			if (flags !== want.flags)
				report($sformatf("flag_bits %0d, expected %0d", flags, want.flags));
			if (letter !== want.letter)
				report($sformatf("letter %0d, expected %0d", letter, want.letter));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic               msg_kind;
	logic signed [31:0] left_value;
	logic signed [31:0] right_value;
	logic [7:0]         flag_bits;
	logic [7:0]         letter;

	line_scoreboard sb;
	logic [7:0]     line_words[$];
	int unsigned    words_sent = 0;
	int unsigned    cycle_count = 0;

	serial_command_line_parser_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.msg_kind    (msg_kind),
		.left_value  (left_value),
		.right_value (right_value),
		.flag_bits   (flag_bits),
		.letter      (letter)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Watchdog. If the run has not ended by the limit, something is stuck.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// The receiver stalls at random, except for one calm stretch of cycles.
	// It changes on the falling edge so the block sees a settled value at the rising edge.
	always @(negedge clk) begin
		if (cycle_count >= STALL_CALM_FROM && cycle_count < STALL_CALM_TO)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < IDLE_PERCENT);
	end

	// Every output word that is taken is checked against the oldest expected message.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(msg_kind, left_value, right_value, flag_bits, letter);
	end

	// The line builders below append words to line_words; send_line then drives them.

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_words.push_back(s[i]);
	endfunction

	function automatic logic [7:0] any_blank();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] any_end();
		return $urandom_range(1) ? CHAR_CR : CHAR_LF;
	endfunction

	function automatic logic [7:0] any_printable();
		return 8'($urandom_range(8'h7E, 8'h20));
	endfunction

	function automatic void put_trailer();
		int unsigned n;
		n = $urandom_range(1) ? $urandom_range(4, 1) : 0;
		for (int i = 0; i < n; i++)
			line_words.push_back(any_printable());
	endfunction

	// A signed decimal. Mostly short, sometimes long enough to saturate, sometimes right
	// at the edges of the 32-bit range.
	function automatic void put_number(bit need_sign);
		int unsigned sign_pick;
		int unsigned style;
		int unsigned digits;
		sign_pick = $urandom_range(9);
		style = $urandom_range(9);
		if (need_sign || sign_pick >= 6)
			line_words.push_back(sign_pick[0] ? CH_MINUS : CH_PLUS);
		if (style == 0) begin
			case ($urandom_range(4))
				0: put_text("2147483647");
				1: put_text("2147483648");
				2: put_text("2147483649");
				3: put_text("4294967295");
				default: put_text("99999999999999999");
			endcase
		end else begin
			digits = (style < 7) ? $urandom_range(3, 1) : $urandom_range(12, 4);
			for (int i = 0; i < digits; i++)
				line_words.push_back(8'(CH_ZERO + $urandom_range(9)));
		end
	endfunction

	// Three numbers after the prefix. With no gap a later number needs a sign of its own,
	// or its digits would simply run on from the previous number.
	function automatic void put_command_line();
		int unsigned gap;
		put_text("CMD");
		for (int k = 0; k < 3; k++) begin
			gap = $urandom_range(2);
			for (int g = 0; g < gap; g++)
				line_words.push_back(any_blank());
			put_number(k > 0 && gap == 0);
		end
		put_trailer();
		line_words.push_back(any_end());
	endfunction

	function automatic void put_letter_line();
		logic [7:0] l;
		put_text("ASL ");
		if ($urandom_range(19) == 0) begin
			l = CH_NUL;
		end else begin
			do
				l = 8'($urandom_range(255, 1));
			while (l == CHAR_CR || l == CHAR_LF);
		end
		line_words.push_back(l);
		put_trailer();
		line_words.push_back(any_end());
	endfunction

	// A well-formed line with one word overwritten, or cut short before its terminator.
	function automatic void put_broken_line();
		int unsigned idx;
		int unsigned keep;
		if ($urandom_range(1))
			put_command_line();
		else
			put_letter_line();
		if ($urandom_range(1)) begin
			idx = $urandom_range(line_words.size() - 2);
			line_words[idx] = ($urandom_range(3) == 0) ? CH_NUL : 8'($urandom_range(255));
		end else begin
			keep = $urandom_range(line_words.size() - 2, 1);
			while (line_words.size() > keep)
				void'(line_words.pop_back());
			line_words.push_back(any_end());
		end
	endfunction

	function automatic void put_noise_line();
		int unsigned n;
		n = $urandom_range(12, 1);
		for (int i = 0; i < n; i++)
			line_words.push_back(8'($urandom_range(255)));
		line_words.push_back(any_end());
	endfunction

	// Filler around the line capacity, then a command; the restart after the dropped
	// character lands somewhere in or before the command.
	function automatic void put_long_line();
		int unsigned n;
		n = $urandom_range(LINE_CAPACITY + 4, LINE_CAPACITY - 6);
		for (int i = 0; i < n; i++)
			line_words.push_back(any_printable());
		put_command_line();
	endfunction

	function automatic void put_random_line();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			put_command_line();
		else if (pick < 65)
			put_letter_line();
		else if (pick < 77)
			put_broken_line();
		else if (pick < 85)
			put_noise_line();
		else if (pick < 96) begin
			line_words.push_back(any_end());
			if ($urandom_range(1))
				line_words.push_back(any_end());
		end else
			put_long_line();
	endfunction

	// Drives one word and returns at the falling edge after it was taken. Idle cycles go
	// in front of the word, so valid is never lowered while a word is waiting.
	task automatic send_word(input logic [7:0] w);
		bit calm;
		calm = (words_sent >= SEND_CALM_FROM && words_sent < SEND_CALM_TO);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= w;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_line();
		while (line_words.size() != 0)
			send_word(line_words.pop_front());
	endtask

	// The sender holds off until every promised message has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_msgs.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned stop_at;
		int unsigned pause_at;
		bit paused;
		sb = new();
		paused = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed lines: a command with signs and one gap, then CR CR LF, where the second CR
		// and the LF are empty lines, the top letter value, and a NUL where the letter should be.
		put_text("CMD-1+2 3");
		line_words.push_back(CHAR_CR);
		line_words.push_back(CHAR_CR);
		line_words.push_back(CHAR_LF);
		put_text("ASL ");
		line_words.push_back(8'hFF);
		line_words.push_back(CHAR_LF);
		put_text("ASL ");
		line_words.push_back(CH_NUL);
		line_words.push_back(CHAR_CR);
		send_line();
		drain_results();

		// Random lines, with one more full pause halfway through.
		stop_at = words_sent + RANDOM_WORDS;
		pause_at = words_sent + RANDOM_WORDS / 2;
		while (words_sent < stop_at) begin
			put_random_line();
			send_line();
			if (!paused && words_sent >= pause_at) begin
				drain_results();
				paused = 1;
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
